// ===== src/pcc_pkg.sv =====
`timescale 1ns / 1ps

package pcc_pkg;

  localparam int unsigned ADDR_W    = 12;
  localparam int unsigned WORD_W    = 16;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned PROD_W    = 13;
  localparam int unsigned PAL_DEPTH = 1 << ADDR_W;

  localparam logic [ADDR_W-1:0] LIMIT_GEN2    = 12'h800;
  localparam logic [ADDR_W-1:0] LIMIT_GEN1    = 12'hC00;
  localparam logic [ADDR_W-1:0] OBJ_SPAN      = 12'h200;
  localparam logic [ADDR_W-1:0] OBJ_BASE      = 12'hC00;
  localparam logic [ADDR_W-1:0] DEST_FLIP     = 12'h00F;
  localparam logic [4:0]        BRIGHT_OFFSET = 5'd15;

  // floor(x / 30) for x < 4709 as (x * 2185) >> 16
  localparam logic [11:0] RECIP_30    = 12'd2185;
  localparam int unsigned RECIP_SHIFT = 16;

  localparam logic REG_GEN_TWO = 1'b0;
  localparam logic REG_LAG_OBJ = 1'b1;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } pcc_wr_t;

endpackage

// ===== src/pcc_ram.sv =====
`timescale 1ns / 1ps

module pcc_ram (
  input  logic                          clk_i,
  input  pcc_pkg::pcc_wr_t              wr_i,
  input  logic                          rd_en_i,
  input  logic [pcc_pkg::ADDR_W-1:0]    rd_addr_i,
  output logic [pcc_pkg::WORD_W-1:0]    rd_data_o
);
  import pcc_pkg::*;

  logic [WORD_W-1:0] mem_q [PAL_DEPTH];
  logic [WORD_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/pcc_scale.sv =====
`timescale 1ns / 1ps

module pcc_scale (
  input  logic                          clk_i,
  input  logic [pcc_pkg::WORD_W-1:0]    word_i,
  output logic [pcc_pkg::CHAN_W-1:0]    red_o,
  output logic [pcc_pkg::CHAN_W-1:0]    green_o,
  output logic [pcc_pkg::CHAN_W-1:0]    blue_o
);
  import pcc_pkg::*;

  logic [4:0]        factor;
  logic [PROD_W-1:0] prod_d [3];
  logic [PROD_W-1:0] prod_q [3];
  logic [24:0]       quot   [3];

  assign factor = {1'b0, word_i[15:12]} + BRIGHT_OFFSET;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_d[i] = PROD_W'({word_i[4*i +: 4], word_i[4*i +: 4]} * factor);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      quot[i] = 25'(prod_q[i] * RECIP_30);
    end
  end

  assign blue_o  = quot[0][RECIP_SHIFT +: CHAN_W];
  assign green_o = quot[1][RECIP_SHIFT +: CHAN_W];
  assign red_o   = quot[2][RECIP_SHIFT +: CHAN_W];

endmodule

// ===== src/palette_change_convert.sv =====
`timescale 1ns / 1ps

// Palette change detector and colour converter.
// Command channel: a palette word (entry_index_i, color_word_i, force_req_i,
// frame_odd_i) is taken at a rising edge with start high and busy low.
// One beat may be issued every cycle; the block is fully pipelined.
// Each command yields exactly one result beat on result_valid_o, registered
// in v1_q, v2_q and res_valid_q. The result carries write_enable_o,
// dest_index_o, red_o, green_o, blue_o and object_base_o; without a write the
// index and colour fields are zero. The receiver cannot stall: a result is
// present for one cycle only.
// Throughput is one word per cycle while busy is low, set by the single read
// and single write port of the source palette memory; a read-after-write to
// the same entry in consecutive cycles is served from a forwarding register.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i (0 = second
// generation, 1 = lagged object palettes) and cfg_data_i. cfg_ready_o is
// always high; write only while no command is in flight.
// Reset: the source palette memory is swept to zero, one entry a cycle, after
// reset release; busy stays high during the sweep.
module palette_change_convert (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [pcc_pkg::ADDR_W-1:0]    entry_index_i,
  input  logic [pcc_pkg::WORD_W-1:0]    color_word_i,
  input  logic                          force_req_i,
  input  logic                          frame_odd_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic                          cfg_data_i,
  output logic                          result_valid_o,
  output logic                          write_enable_o,
  output logic [pcc_pkg::ADDR_W-1:0]    dest_index_o,
  output logic [pcc_pkg::CHAN_W-1:0]    red_o,
  output logic [pcc_pkg::CHAN_W-1:0]    green_o,
  output logic [pcc_pkg::CHAN_W-1:0]    blue_o,
  output logic [pcc_pkg::ADDR_W-1:0]    object_base_o
);
  import pcc_pkg::*;

  logic gen_two_q, lag_obj_q;
  logic clearing_q;
  logic [ADDR_W-1:0] clr_addr_q;

  logic accept;
  logic lagged;
  logic in_range;
  logic [ADDR_W-1:0] current_base;
  logic [ADDR_W-1:0] slot;

  logic              v1_q, range1_q, force1_q;
  logic [ADDR_W-1:0] slot1_q, base1_q;
  logic [WORD_W-1:0] word1_q;

  logic              lw_valid_q;
  logic [ADDR_W-1:0] lw_addr_q;
  logic [WORD_W-1:0] lw_data_q;

  logic [WORD_W-1:0] rd_data;
  logic [WORD_W-1:0] stored;
  logic              we1;
  pcc_wr_t           wr;

  logic              v2_q, we2_q;
  logic [ADDR_W-1:0] slot2_q, base2_q;
  logic [CHAN_W-1:0] red_s, green_s, blue_s;

  logic              res_valid_q, res_we_q;
  logic [ADDR_W-1:0] res_dest_q, res_base_q;
  logic [CHAN_W-1:0] res_red_q, res_green_q, res_blue_q;

  assign busy        = clearing_q;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !clearing_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_two_q <= 1'b0;
      lag_obj_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_GEN_TWO: gen_two_q <= cfg_data_i;
        REG_LAG_OBJ: lag_obj_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == ADDR_W'(PAL_DEPTH - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  // Slot resolution
  assign lagged       = gen_two_q && lag_obj_q;
  assign current_base = OBJ_BASE | (frame_odd_i ? OBJ_SPAN : '0);
  assign in_range     = entry_index_i < (gen_two_q ? LIMIT_GEN2 : LIMIT_GEN1);

  always_comb begin
    slot = entry_index_i;
    if (lagged && (entry_index_i < OBJ_SPAN)) begin
      slot = (force_req_i ? current_base : (current_base ^ OBJ_SPAN)) + entry_index_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      range1_q <= in_range;
      force1_q <= force_req_i;
      slot1_q  <= slot;
      word1_q  <= color_word_i;
      base1_q  <= lagged ? current_base : '0;
    end
  end

  pcc_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_en_i   (accept),
    .rd_addr_i (slot),
    .rd_data_o (rd_data)
  );

  // Compare against the stored copy, forwarding the previous cycle's write
  assign stored = (lw_valid_q && (lw_addr_q == slot1_q)) ? lw_data_q : rd_data;
  assign we1    = v1_q && range1_q && (force1_q || (stored != word1_q));

  always_comb begin
    if (clearing_q) begin
      wr.en   = 1'b1;
      wr.addr = clr_addr_q;
      wr.data = '0;
    end else begin
      wr.en   = we1;
      wr.addr = slot1_q;
      wr.data = word1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_valid_q <= 1'b0;
    end else begin
      lw_valid_q <= we1;
    end
  end

  always_ff @(posedge clk_i) begin
    lw_addr_q <= slot1_q;
    lw_data_q <= word1_q;
  end

  pcc_scale u_scale (
    .clk_i   (clk_i),
    .word_i  (word1_q),
    .red_o   (red_s),
    .green_o (green_s),
    .blue_o  (blue_s)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q  <= 1'b0;
      we2_q <= 1'b0;
    end else begin
      v2_q  <= v1_q;
      we2_q <= we1;
    end
  end

  always_ff @(posedge clk_i) begin
    slot2_q <= slot1_q;
    base2_q <= base1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      res_we_q    <= 1'b0;
    end else begin
      res_valid_q <= v2_q;
      res_we_q    <= we2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_base_q  <= base2_q;
    res_dest_q  <= we2_q ? (slot2_q ^ DEST_FLIP) : '0;
    res_red_q   <= we2_q ? red_s   : '0;
    res_green_q <= we2_q ? green_s : '0;
    res_blue_q  <= we2_q ? blue_s  : '0;
  end

  assign result_valid_o = res_valid_q;
  assign write_enable_o = res_we_q;
  assign dest_index_o   = res_dest_q;
  assign red_o          = res_red_q;
  assign green_o        = res_green_q;
  assign blue_o         = res_blue_q;
  assign object_base_o  = res_base_q;

`ifndef ASSERT_OFF
  a_we_has_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_enable_o |-> result_valid_o)
    else $error("write enable without result strobe");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##3 result_valid_o)
    else $error("result missing three cycles after command");

  a_no_write_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !v1_q && !result_valid_o)
    else $error("pipeline active during memory sweep");

  a_fwd_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we1 |=> lw_valid_q && (lw_data_q == $past(word1_q)))
    else $error("forwarding register missed a write");
`endif

endmodule

// ===== dv/palette_change_convert_tb.sv =====
`timescale 1ns / 1ps

module palette_change_convert_tb;
  import pcc_pkg::*;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] dest;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [ADDR_W-1:0] obj_base;
  } palette_write_t;

  class palette_shadow;
    logic [WORD_W-1:0] shadow_words [PAL_DEPTH];
    logic              gen_two;
    logic              lag_obj;
    palette_write_t    pending_writes [$];
    int unsigned       mismatches;
    int unsigned       writes_seen;
    int unsigned       skips_seen;

    function new();
      foreach (shadow_words[i]) shadow_words[i] = '0;
      gen_two = 1'b0;
      lag_obj = 1'b0;
      mismatches = 0;
      writes_seen = 0;
      skips_seen = 0;
    endfunction

    function void set_reg(logic idx, logic val);
      if (idx == REG_GEN_TWO) gen_two = val;
      else lag_obj = val;
    endfunction

    function logic [CHAN_W-1:0] scaled(logic [3:0] nib, logic [4:0] factor);
      int unsigned prod;
      prod = int'(nib) * 17 * int'(factor);
      scaled = CHAN_W'(prod / 30);
    endfunction

    function void note_word(logic [ADDR_W-1:0] idx, logic [WORD_W-1:0] word,
                            logic frc, logic odd);
      palette_write_t    exp_wr;
      logic              lagged;
      logic [ADDR_W-1:0] cur;
      logic [ADDR_W-1:0] lim;
      logic [ADDR_W-1:0] slot;
      logic [4:0]        factor;
      lagged = gen_two && lag_obj;
      cur    = odd ? (OBJ_BASE + OBJ_SPAN) : OBJ_BASE;
      lim    = gen_two ? LIMIT_GEN2 : LIMIT_GEN1;
      exp_wr = '0;
      exp_wr.obj_base = lagged ? cur : '0;
      if (idx < lim) begin
        if (lagged && idx < OBJ_SPAN) slot = (frc ? cur : (cur ^ OBJ_SPAN)) + idx;
        else slot = idx;
        if (frc || shadow_words[slot] != word) begin
          shadow_words[slot] = word;
          factor       = {1'b0, word[15:12]} + BRIGHT_OFFSET;
          exp_wr.we    = 1'b1;
          exp_wr.dest  = slot ^ DEST_FLIP;
          exp_wr.red   = scaled(word[11:8], factor);
          exp_wr.green = scaled(word[7:4], factor);
          exp_wr.blue  = scaled(word[3:0], factor);
        end
      end
      pending_writes.push_back(exp_wr);
    endfunction

    function void check_write(palette_write_t got);
      palette_write_t exp_wr;
      if (pending_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result beat we=%b dest=%h",
                   $realtime, got.we, got.dest);
        return;
      end
      exp_wr = pending_writes.pop_front();
      if (got.we) writes_seen++;
      else skips_seen++;
      if (got.we !== exp_wr.we || got.dest !== exp_wr.dest || got.red !== exp_wr.red ||
          got.green !== exp_wr.green || got.blue !== exp_wr.blue ||
          got.obj_base !== exp_wr.obj_base) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: mismatch exp we=%b dest=%h rgb=%h/%h/%h obj=%h",
                    " got we=%b dest=%h rgb=%h/%h/%h obj=%h"},
                   $realtime, exp_wr.we, exp_wr.dest, exp_wr.red, exp_wr.green, exp_wr.blue,
                   exp_wr.obj_base, got.we, got.dest, got.red, got.green, got.blue,
                   got.obj_base);
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [ADDR_W-1:0] entry_index_i;
  logic [WORD_W-1:0] color_word_i;
  logic              force_req_i;
  logic              frame_odd_i;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic              cfg_index_i;
  logic              cfg_data_i;
  logic              result_valid_o;
  logic              write_enable_o;
  logic [ADDR_W-1:0] dest_index_o;
  logic [CHAN_W-1:0] red_o;
  logic [CHAN_W-1:0] green_o;
  logic [CHAN_W-1:0] blue_o;
  logic [ADDR_W-1:0] object_base_o;

  palette_shadow     shadow = new();
  int unsigned       beats_sent;
  int unsigned       reg_writes;
  logic [ADDR_W-1:0] recent_idx [8];
  logic [WORD_W-1:0] recent_word [8];
  logic              recent_odd [8];
  int unsigned       recent_n;

  palette_change_convert dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .entry_index_i  (entry_index_i),
    .color_word_i   (color_word_i),
    .force_req_i    (force_req_i),
    .frame_odd_i    (frame_odd_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .write_enable_o (write_enable_o),
    .dest_index_o   (dest_index_o),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .object_base_o  (object_base_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o)
      shadow.check_write({write_enable_o, dest_index_o, red_o, green_o, blue_o, object_base_o});
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_word(logic [ADDR_W-1:0] idx, logic [WORD_W-1:0] word,
                           logic frc, logic odd);
    @(negedge clk_i);
    start         <= 1'b1;
    entry_index_i <= idx;
    color_word_i  <= word;
    force_req_i   <= frc;
    frame_odd_i   <= odd;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    shadow.note_word(idx, word, frc, odd);
    recent_idx[beats_sent % 8]  = idx;
    recent_word[beats_sent % 8] = word;
    recent_odd[beats_sent % 8]  = odd;
    beats_sent++;
    if (recent_n < 8) recent_n++;
  endtask

  task automatic hold_idle(int unsigned n);
    @(negedge clk_i);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic drain();
    hold_idle(1);
    while (shadow.pending_writes.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    shadow.set_reg(idx, val);
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_words(int unsigned n, int unsigned idle_pct);
    int unsigned       pick;
    int unsigned       k;
    int unsigned       r;
    logic [ADDR_W-1:0] idx;
    logic [WORD_W-1:0] word;
    logic              frc;
    logic              odd;
    logic [ADDR_W-1:0] edges [8];
    edges = '{12'h000, 12'h1FF, 12'h200, 12'h7FF, 12'h800, 12'hBFF, 12'hC00, 12'hFFF};
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      word = WORD_W'($urandom);
      frc  = ($urandom_range(0, 3) == 0);
      odd  = 1'($urandom_range(0, 1));
      if (pick < 25 && recent_n > 0) begin
        // repeat an earlier beat unforced, mostly expecting no write
        r    = $urandom_range(0, recent_n - 1);
        idx  = recent_idx[r];
        word = recent_word[r];
        odd  = recent_odd[r];
        frc  = 1'b0;
      end else if (pick < 35) begin
        idx = edges[$urandom_range(0, 7)];
      end else if (pick < 70) begin
        idx = ADDR_W'($urandom_range(0, 12'h1FF));
      end else begin
        idx = ADDR_W'($urandom);
      end
      send_word(idx, word, frc, odd);
      if ((k / 30) % 3 != 1 && $urandom_range(0, 99) < idle_pct)
        hold_idle($urandom_range(1, 4));
    end
  endtask

  initial begin
    int unsigned       ph;
    int unsigned       idle_pct [5];
    logic              gen_set [5];
    logic              lag_set [5];
    logic [ADDR_W-1:0] lim;
    idle_pct      = '{0, 56, 19, 0, 56};
    gen_set       = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    lag_set       = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
    beats_sent    = 0;
    reg_writes    = 0;
    recent_n      = 0;
    rst_ni        = 1'b0;
    start         = 1'b0;
    entry_index_i = '0;
    color_word_i  = '0;
    force_req_i   = 1'b0;
    frame_odd_i   = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_GEN_TWO;
    cfg_data_i    = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    for (ph = 0; ph < 5; ph++) begin
      drain();
      write_reg(REG_GEN_TWO, gen_set[ph]);
      write_reg(REG_LAG_OBJ, lag_set[ph]);
      lim = gen_set[ph] ? LIMIT_GEN2 : LIMIT_GEN1;
      send_word(12'h000, 16'hFFFF, 1'b0, 1'b1);
      send_word(12'h000, 16'hFFFF, 1'b0, 1'b1);
      send_word(12'h1FF, 16'h0F0F, 1'b1, 1'b0);
      send_word(lim - 1'b1, 16'hF5A0, 1'b0, 1'b0);
      send_word(lim, 16'h1234, 1'b1, 1'b1);
      random_words(110, idle_pct[ph]);
    end
    drain();

    $display("Sent %0d palette words over 5 mode settings (%0d register writes).",
             beats_sent, reg_writes);
    $display("Results: %0d converted writes, %0d without a write, %0d mismatches.",
             shadow.writes_seen, shadow.skips_seen, shadow.mismatches);
    if (shadow.mismatches == 0 && shadow.pending_writes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
